[sv/kmsp_pkg.sv]
package kmsp_pkg;

   localparam int MACRO_COUNT  = 16;
   localparam int DELAY_DIGITS = 5;
   localparam int LOOK_DEPTH   = 5;
   localparam int DIG_LIMIT    = (DELAY_DIGITS < LOOK_DEPTH) ? DELAY_DIGITS : LOOK_DEPTH;
   localparam int LOOK_IDX_W   = 3;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_W   = 1;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_PIPE = 8'h7C;
   localparam logic [15:0] EXT_REMAP_LIMIT = 16'hFF00;

   localparam logic [3:0] ACT_CHAR       = 4'd0;
   localparam logic [3:0] ACT_BASIC_TAP  = 4'd1;
   localparam logic [3:0] ACT_BASIC_DOWN = 4'd2;
   localparam logic [3:0] ACT_BASIC_UP   = 4'd3;
   localparam logic [3:0] ACT_EXT_TAP    = 4'd4;
   localparam logic [3:0] ACT_EXT_DOWN   = 4'd5;
   localparam logic [3:0] ACT_EXT_UP     = 4'd6;
   localparam logic [3:0] ACT_DELAY      = 4'd7;
   localparam logic [3:0] ACT_END        = 4'd8;

   localparam logic [2:0] CSR_MACRO_SELECT = 3'd0;
   localparam logic [2:0] CSR_PREFIX_BYTE  = 3'd1;
   localparam logic [2:0] CSR_BASIC_BASE   = 3'd2;
   localparam logic [2:0] CSR_EXT_BASE     = 3'd3;
   localparam logic [2:0] CSR_DELAY_CODE   = 3'd4;

   typedef struct packed {
      logic [3:0] macro_select;
      logic [7:0] prefix_byte;
      logic [7:0] basic_code_base;
      logic [7:0] ext_code_base;
      logic [7:0] delay_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      macro_select:    4'd0,
      prefix_byte:     8'd1,
      basic_code_base: 8'd1,
      ext_code_base:   8'd5,
      delay_code:      8'd4
   };

   typedef struct packed {
      logic is_zero;
      logic is_digit;
      logic is_pipe;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           start;
      logic           last;
      byte_class_type cls;
   } byte_info_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [15:0] key_value;
      logic [16:0] delay_ms;
      logic        macro_done;
   } rsp_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c.is_zero  = (b == 8'h00);
      c.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      c.is_pipe  = (b == CHAR_PIPE);
      return c;
   endfunction

endpackage

[sv/kmsp_front.sv]
module kmsp_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_buffer_start,
   input  logic                      req_buffer_end,
   input  kmsp_pkg::fifo_status_type fifo_st,
   output logic                      push,
   output kmsp_pkg::byte_info_type   info
);

   assign req_ready = !fifo_st.full;
   assign push      = req_valid && !fifo_st.full;

   always_comb begin
      info.data  = req_data_byte;
      info.start = req_buffer_start;
      info.last  = req_buffer_end;
      info.cls   = kmsp_pkg::classify(req_data_byte);
   end

endmodule

[sv/kmsp_fifo.sv]
module kmsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kmsp_pkg::byte_info_type   push_data,
   input  logic                      pop,
   output kmsp_pkg::byte_info_type   head,
   output kmsp_pkg::fifo_status_type status
);

   kmsp_pkg::byte_info_type mem [kmsp_pkg::FIFO_DEPTH];

   logic [kmsp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [kmsp_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [kmsp_pkg::FIFO_PTR_W:0]   cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign status.full  = (cnt_ff == (kmsp_pkg::FIFO_PTR_W+1)'(kmsp_pkg::FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[sv/kmsp_back.sv]
module kmsp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  kmsp_pkg::cfg_type         cfg,
   input  kmsp_pkg::byte_info_type   head,
   input  kmsp_pkg::fifo_status_type fifo_st,
   output logic                      pop,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output kmsp_pkg::rsp_type         rsp
);

   localparam logic [3:0] PH_SKIP   = 4'd0;
   localparam logic [3:0] PH_IDLE   = 4'd1;
   localparam logic [3:0] PH_CHAR   = 4'd2;
   localparam logic [3:0] PH_CMD    = 4'd3;
   localparam logic [3:0] PH_BASIC  = 4'd4;
   localparam logic [3:0] PH_EXTLO  = 4'd5;
   localparam logic [3:0] PH_EXTHI  = 4'd6;
   localparam logic [3:0] PH_DIGITS = 4'd7;
   localparam logic [3:0] PH_D1     = 4'd8;

   localparam int LW = kmsp_pkg::LOOK_IDX_W;

   logic [3:0]    ph_ff, ph_in, ph0;
   logic [3:0]    term_ff, term_in, term0;
   logic [LW-1:0] cnt_ff, cnt_in, cnt0, cnt_new;
   logic [16:0]   acc_ff, acc_in, acc0, acc_new;
   logic [3:0]    pcmd_ff, pcmd_in;
   logic [7:0]    plow_ff, plow_in;
   logic          endp_ff, endp_in;
   logic [LW-1:0] rcnt_ff;
   logic [7:0]    look_ff   [kmsp_pkg::LOOK_DEPTH];
   logic [7:0]    replay_ff [kmsp_pkg::LOOK_DEPTH];
   logic [7:0]    saved     [kmsp_pkg::LOOK_DEPTH];
   logic [7:0]    replay_in [kmsp_pkg::LOOK_DEPTH];
   logic          out_valid_ff;
   kmsp_pkg::rsp_type out_ff;

   logic          step_go, use_replay, use_end, use_fifo, cur_start;
   logic [7:0]    b;
   kmsp_pkg::byte_class_type cls;
   logic          in_range, char_mode, fin, emit;
   kmsp_pkg::rsp_type em;
   logic          look_we, rp_load, rp_off2, rp_clear;
   logic [LW-1:0] rp_n;
   logic [7:0]    d0, d1, e0, e1;
   logic [16:0]   bias_ms;
   logic [15:0]   kc;
   logic [8:0]    basic_hi, ext_hi;

   assign step_go    = !out_valid_ff || rsp_ready;
   assign use_replay = (rcnt_ff != '0);
   assign use_end    = !use_replay && endp_ff;
   assign use_fifo   = !use_replay && !endp_ff && !fifo_st.empty;
   assign pop        = step_go && use_fifo;
   assign cur_start  = use_fifo && head.start;
   assign b          = use_replay ? replay_ff[0] : head.data;
   assign cls        = use_replay ? kmsp_pkg::classify(replay_ff[0]) : head.cls;

   assign ph0   = cur_start ? PH_SKIP : ph_ff;
   assign term0 = cur_start ? 4'd0 : term_ff;
   assign cnt0  = cur_start ? '0 : cnt_ff;
   assign acc0  = cur_start ? 17'd0 : acc_ff;

   assign in_range  = int'(cfg.macro_select) < kmsp_pkg::MACRO_COUNT;
   assign char_mode = (ph0 == PH_CHAR) ||
                      (ph0 == PH_SKIP && in_range && term0 == cfg.macro_select);

   // decimal accumulate: acc * 10 + digit, kept to 17 bits
   assign acc_new = {acc0[13:0], 3'b000} + {acc0[15:0], 1'b0} + {13'd0, b[3:0]};
   assign cnt_new = cnt0 + 1'b1;

   always_comb begin
      for (int i = 0; i < kmsp_pkg::LOOK_DEPTH; i++) begin
         saved[i] = (LW'(i) == cnt0) ? b : look_ff[i];
      end
      for (int i = 0; i < kmsp_pkg::LOOK_DEPTH; i++) begin
         if (!rp_off2) begin
            replay_in[i] = saved[i];
         end else if (i + 2 < kmsp_pkg::LOOK_DEPTH) begin
            replay_in[i] = saved[i+2];
         end else begin
            replay_in[i] = 8'h00;
         end
      end
   end

   // biased delay: (d0 - 1) + (d1 - 1) * 255
   assign d0      = (ph0 == PH_D1) ? plow_ff : look_ff[0];
   assign d1      = (ph0 == PH_D1 || cnt0 == LW'(1)) ? b : look_ff[1];
   assign e0      = d0 - 8'd1;
   assign e1      = d1 - 8'd1;
   assign bias_ms = {1'b0, {e1, 8'h00} - {8'h00, e1}} + {9'd0, e0};

   assign kc       = ({b, plow_ff} > kmsp_pkg::EXT_REMAP_LIMIT) ? {plow_ff, 8'h00}
                                                                : {b, plow_ff};
   assign basic_hi = {1'b0, cfg.basic_code_base} + 9'd2;
   assign ext_hi   = {1'b0, cfg.ext_code_base} + 9'd2;

   always_comb begin
      ph_in    = ph0;
      term_in  = term0;
      cnt_in   = cnt0;
      acc_in   = acc0;
      pcmd_in  = pcmd_ff;
      plow_in  = plow_ff;
      endp_in  = endp_ff;
      emit     = 1'b0;
      em       = '0;
      fin      = 1'b0;
      look_we  = 1'b0;
      rp_load  = 1'b0;
      rp_off2  = 1'b0;
      rp_n     = '0;
      rp_clear = 1'b0;
      if (step_go && use_end) begin
         endp_in = 1'b0;
         if (ph_ff == PH_SKIP) begin
            ph_in = PH_IDLE;
         end else if (ph_ff != PH_IDLE) begin
            fin = 1'b1;
         end
      end else if (step_go && (use_replay || use_fifo)) begin
         if (use_fifo && head.last) begin
            endp_in = 1'b1;
         end
         if (char_mode) begin
            ph_in = PH_CHAR;
            if (cls.is_zero) begin
               fin = 1'b1;
            end else if (b == cfg.prefix_byte) begin
               ph_in = PH_CMD;
            end else begin
               emit         = 1'b1;
               em.action    = kmsp_pkg::ACT_CHAR;
               em.key_value = {8'h00, b};
            end
         end else begin
            case (ph0)
               PH_SKIP: begin
                  if (!in_range) begin
                     ph_in = PH_IDLE;
                  end else if (cls.is_zero) begin
                     term_in = term0 + 4'd1;
                  end
               end
               PH_CMD: begin
                  if (cls.is_zero) begin
                     fin = 1'b1;
                  end else if (b >= cfg.basic_code_base && {1'b0, b} <= basic_hi) begin
                     pcmd_in = kmsp_pkg::ACT_BASIC_TAP + 4'(b - cfg.basic_code_base);
                     ph_in   = PH_BASIC;
                  end else if (b >= cfg.ext_code_base && {1'b0, b} <= ext_hi) begin
                     pcmd_in = kmsp_pkg::ACT_EXT_TAP + 4'(b - cfg.ext_code_base);
                     ph_in   = PH_EXTLO;
                  end else if (b == cfg.delay_code) begin
                     cnt_in = '0;
                     acc_in = 17'd0;
                     ph_in  = PH_DIGITS;
                  end else begin
                     ph_in = PH_CHAR;
                  end
               end
               PH_BASIC: begin
                  if (!cls.is_zero) begin
                     emit         = 1'b1;
                     em.action    = pcmd_ff;
                     em.key_value = {8'h00, b};
                  end
                  ph_in = PH_CHAR;
               end
               PH_EXTLO: begin
                  if (cls.is_zero) begin
                     ph_in = PH_CHAR;
                  end else begin
                     plow_in = b;
                     ph_in   = PH_EXTHI;
                  end
               end
               PH_EXTHI: begin
                  if (!cls.is_zero) begin
                     emit         = 1'b1;
                     em.action    = pcmd_ff;
                     em.key_value = kc;
                  end
                  ph_in = PH_CHAR;
               end
               PH_DIGITS: begin
                  look_we = (int'(cnt0) < kmsp_pkg::LOOK_DEPTH);
                  cnt_in  = cnt_new;
                  if (cls.is_digit) begin
                     acc_in = acc_new;
                     if (int'(cnt_new) >= kmsp_pkg::DIG_LIMIT) begin
                        cnt_in      = '0;
                        ph_in       = PH_CHAR;
                        emit        = 1'b1;
                        em.action   = kmsp_pkg::ACT_DELAY;
                        em.delay_ms = acc_new;
                        rp_load     = 1'b1;
                        rp_n        = cnt_new;
                     end
                  end else if (cls.is_pipe && cnt0 != '0) begin
                     cnt_in      = '0;
                     ph_in       = PH_CHAR;
                     emit        = 1'b1;
                     em.action   = kmsp_pkg::ACT_DELAY;
                     em.delay_ms = acc0;
                  end else begin
                     // digit form failed, fall back to two biased bytes
                     cnt_in = '0;
                     if (cnt0 == '0) begin
                        plow_in = b;
                        ph_in   = PH_D1;
                     end else if (d0 == 8'h00 || d1 == 8'h00) begin
                        fin = 1'b1;
                     end else begin
                        ph_in       = PH_CHAR;
                        emit        = 1'b1;
                        em.action   = kmsp_pkg::ACT_DELAY;
                        em.delay_ms = bias_ms;
                        rp_load     = 1'b1;
                        rp_off2     = 1'b1;
                        rp_n        = cnt0 - LW'(1);
                     end
                  end
               end
               PH_D1: begin
                  if (d0 == 8'h00 || d1 == 8'h00) begin
                     fin = 1'b1;
                  end else begin
                     ph_in       = PH_CHAR;
                     emit        = 1'b1;
                     em.action   = kmsp_pkg::ACT_DELAY;
                     em.delay_ms = bias_ms;
                  end
               end
               default: begin
                  ph_in = ph0;
               end
            endcase
         end
      end
      if (fin) begin
         ph_in         = PH_IDLE;
         cnt_in        = '0;
         rp_clear      = 1'b1;
         rp_load       = 1'b0;
         emit          = 1'b1;
         em            = '0;
         em.action     = kmsp_pkg::ACT_END;
         em.macro_done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && look_we) begin
         look_ff[cnt0] <= b;
      end
      if (step_go && rp_load) begin
         replay_ff <= replay_in;
      end else if (step_go && use_replay) begin
         for (int i = 0; i < kmsp_pkg::LOOK_DEPTH - 1; i++) begin
            replay_ff[i] <= replay_ff[i+1];
         end
         replay_ff[kmsp_pkg::LOOK_DEPTH-1] <= 8'h00;
      end
      if (step_go) begin
         out_ff <= em;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= PH_SKIP;
         term_ff      <= 4'd0;
         cnt_ff       <= '0;
         acc_ff       <= 17'd0;
         pcmd_ff      <= 4'd0;
         plow_ff      <= 8'd0;
         endp_ff      <= 1'b0;
         rcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else if (step_go) begin
         ph_ff        <= ph_in;
         term_ff      <= term_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         pcmd_ff      <= pcmd_in;
         plow_ff      <= plow_in;
         endp_ff      <= endp_in;
         out_valid_ff <= emit;
         if (rp_clear) begin
            rcnt_ff <= '0;
         end else if (rp_load) begin
            rcnt_ff <= rp_n;
         end else if (use_replay) begin
            rcnt_ff <= rcnt_ff - LW'(1);
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

[sv/keyboard_macro_stream_parser.sv]
// Bytes of the macro buffer are accepted into a two-entry queue and decoded by a back end
// that handles one byte per cycle, giving at most one result per cycle through a registered
// output. A delay that closes out at its digit limit or falls back to the biased form
// replays up to five looked-at bytes, and a buffer end flag takes a back-end step of its
// own. The back end holds while its output register is full and not taken. The user must
// write configuration registers only while the block is idle; the block does not enforce it.
module keyboard_macro_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_start,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_action,
   output logic [15:0] rsp_key_value,
   output logic [16:0] rsp_delay_ms,
   output logic        rsp_macro_done,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   kmsp_pkg::cfg_type         cfg_ff;
   kmsp_pkg::fifo_status_type fifo_st;
   kmsp_pkg::byte_info_type   push_info, head;
   kmsp_pkg::rsp_type         rsp;
   logic                      push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= kmsp_pkg::CFG_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            kmsp_pkg::CSR_MACRO_SELECT: cfg_ff.macro_select    <= csr_wdata[3:0];
            kmsp_pkg::CSR_PREFIX_BYTE:  cfg_ff.prefix_byte     <= csr_wdata;
            kmsp_pkg::CSR_BASIC_BASE:   cfg_ff.basic_code_base <= csr_wdata;
            kmsp_pkg::CSR_EXT_BASE:     cfg_ff.ext_code_base   <= csr_wdata;
            kmsp_pkg::CSR_DELAY_CODE:   cfg_ff.delay_code      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   kmsp_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_buffer_start (req_buffer_start),
      .req_buffer_end   (req_buffer_end),
      .fifo_st          (fifo_st),
      .push             (push),
      .info             (push_info)
   );

   kmsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_info),
      .pop       (pop),
      .head      (head),
      .status    (fifo_st)
   );

   kmsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .fifo_st   (fifo_st),
      .pop       (pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_action     = rsp.action;
   assign rsp_key_value  = rsp.key_value;
   assign rsp_delay_ms   = rsp.delay_ms;
   assign rsp_macro_done = rsp.macro_done;

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(fifo_st.full && fifo_st.empty))
      else $error("request queue reports full and empty together");

   a_done_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_macro_done |-> rsp_action == kmsp_pkg::ACT_END)
      else $error("macro done flagged on a result that is not an end");

   a_delay_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delay_ms != 17'd0 |-> rsp_action == kmsp_pkg::ACT_DELAY)
      else $error("nonzero delay on a result that is not a delay");

endmodule
